### rtl/core/psdq_pkg.sv
// psdq_pkg: shared types and constants for the per-socket packet delay queue
// no dependencies

package psdq_pkg;

   localparam logic OP_ENQUEUE = 1'b0;

   localparam logic [2:0] ST_ENQUEUED  = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_DELIVERED = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NOT_DUE   = 3'd4;

   localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [9:0]  US_PER_MS = 10'd1000;

   typedef struct packed {
      logic [15:0] packet_handle;
      logic [47:0] source_address;
      logic [15:0] payload_size;
      logic [15:0] wire_size;
      logic        stream_flag;
   } desc_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_handle;
      logic [47:0] out_source;
      logic [39:0] release_time;
      logic [15:0] out_payload_size;
      logic [15:0] out_wire_size;
      logic        out_stream_flag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request, start free search
      logic mul;         // compute release time
      logic scan;        // free search step
      logic rd_head;     // read head entry
      logic rd_next;     // start walk after head
      logic wr_new;      // write new entry
      logic link_head;   // new entry becomes head
      logic link_after;  // new entry links to next
      logic link_prev;   // prev links to new entry
      logic advance;     // prev <= next
      logic pop;         // pop head
      logic set_rsp;     // load response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_enq;
      logic sock_bad;
      logic scan_done;
      logic pool_full;
      logic head_nil;
      logic head_later;  // head time > rel
      logic head_not_due;
      logic next_nil;
      logic next_earlier; // next time < rel
   } stat_type;

endpackage

### rtl/core/psdq_if.sv
// psdq_if: valid/ready channel carrying a generic payload
// no dependencies

interface psdq_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/psdq_ram.sv
// psdq_ram: generic single write, single read RAM with registered read
// no dependencies

module psdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/psdq_ctrl.sv
// psdq_ctrl: sequencer for enqueue walk and dequeue pop
// depends on psdq_pkg

module psdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   output logic                 req_ready,
   input  logic                 rsp_full,
   input  psdq_pkg::stat_type   stat,
   output psdq_pkg::cmd_type    cmd
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_SCAN  = 10'b0000000010,
      S_HEAD  = 10'b0000000100,
      S_HWAIT = 10'b0000001000,
      S_HDEC  = 10'b0000010000,
      S_NWAIT = 10'b0000100000,
      S_NDEC  = 10'b0001000000,
      S_DONE  = 10'b0010000000,
      S_DEQ   = 10'b0100000000,
      S_LINK  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_full;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            cmd.mul = 1'b1;
            cmd.rd_head = 1'b1;
            if (!stat.is_enq) begin
               state_in = S_HWAIT;
            end else if (stat.scan_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (stat.sock_bad || stat.pool_full) begin
               cmd.set_rsp = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_head = 1'b1;
               cmd.wr_new = 1'b1;
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: begin
            cmd.rd_head = 1'b1;
            state_in = stat.is_enq ? S_HDEC : S_DEQ;
         end
         S_HDEC: begin
            if (stat.head_nil || stat.head_later) begin
               cmd.link_head = 1'b1;
               cmd.set_rsp = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in = S_NWAIT;
            end
         end
         S_NWAIT: begin
            state_in = S_NDEC;
         end
         S_NDEC: begin
            if (stat.next_nil || !stat.next_earlier) begin
               cmd.link_after = 1'b1;
               cmd.set_rsp = 1'b1;
               state_in = S_LINK;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_NWAIT;
            end
         end
         S_LINK: begin
            cmd.link_prev = 1'b1;
            state_in = S_IDLE;
         end
         S_DEQ: begin
            if (!stat.sock_bad && !stat.head_nil && !stat.head_not_due) begin
               cmd.pop = 1'b1;
            end
            cmd.set_rsp = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### rtl/core/psdq_dp.sv
// psdq_dp: request registers, pool RAMs, free map, heads and response register
// depends on psdq_pkg, psdq_ram

module psdq_dp #(
   parameter int SOCKET_COUNT = 6,
   parameter int POOL_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_in,
   input  logic [2:0]         sock_in,
   input  logic [39:0]        arrival_in,
   input  logic [15:0]        delay_in,
   input  logic [39:0]        now_in,
   input  psdq_pkg::desc_type desc_in,
   input  psdq_pkg::cmd_type  cmd,
   output psdq_pkg::stat_type stat,
   input  logic               rsp_take,
   output logic               rsp_full,
   output psdq_pkg::rsp_type  rsp
);
   localparam int AW = $clog2(POOL_ENTRIES);
   localparam int SW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
   localparam logic [AW:0] NIL = {1'b1, {AW{1'b0}}};

   logic          op_ff;
   logic [2:0]    sock_ff;
   logic [39:0]   arr_ff, now_ff, rel_ff;
   logic [15:0]   dly_ff;
   psdq_pkg::desc_type desc_ff;
   logic [AW:0]   scan_ff;
   logic [AW-1:0] new_ff, prev_ff;
   logic [AW:0]   nxt_ff;
   logic          found_ff;
   logic [POOL_ENTRIES-1:0] free_ff;
   logic [AW:0]   head_ff [SOCKET_COUNT];
   logic          rsp_full_ff;
   psdq_pkg::rsp_type rsp_ff;
   logic [25:0]   prod_ff;

   logic [SW-1:0] sidx;
   logic          sock_bad;
   logic [AW:0]   head_cur;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   link_q;
   logic [39:0]   time_q;
   psdq_pkg::desc_type desc_q;
   logic          lk_we;
   logic [AW-1:0] lk_wa;
   logic [AW:0]   lk_wd;
   logic [41:0]   rel_full;
   psdq_pkg::rsp_type rsp_in;

   assign sock_bad = int'(sock_ff) >= SOCKET_COUNT;
   assign sidx = sock_bad ? '0 : SW'(sock_ff);
   assign head_cur = head_ff[sidx];

   // head entry or walk successor
   assign rd_addr = cmd.rd_head ? head_cur[AW-1:0] : nxt_ff[AW-1:0];

   // memories: link, time, descriptor
   psdq_ram #(.WIDTH(AW + 1), .DEPTH(POOL_ENTRIES)) u_link (
      .clock, .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(rd_addr), .rd_data(link_q));
   psdq_ram #(.WIDTH(40), .DEPTH(POOL_ENTRIES)) u_time (
      .clock, .wr_en(cmd.wr_new), .wr_addr(new_ff), .wr_data(rel_ff),
      .rd_addr(rd_addr), .rd_data(time_q));
   psdq_ram #(.WIDTH($bits(psdq_pkg::desc_type)), .DEPTH(POOL_ENTRIES)) u_desc (
      .clock, .wr_en(cmd.wr_new), .wr_addr(new_ff), .wr_data(desc_ff),
      .rd_addr(rd_addr), .rd_data(desc_q));

   // link writes
   always_comb begin
      lk_we = 1'b0;
      lk_wa = new_ff;
      lk_wd = head_cur;
      if (cmd.link_head) begin
         lk_we = 1'b1;
      end else if (cmd.link_after) begin
         lk_we = 1'b1;
         lk_wd = nxt_ff;
      end else if (cmd.link_prev) begin
         lk_we = 1'b1;
         lk_wa = prev_ff;
         lk_wd = {1'b0, new_ff};
      end
   end

   assign rel_full = {2'b0, arr_ff} + {16'b0, prod_ff};

   always_comb begin
      rsp_in = '0;
      if (op_ff == psdq_pkg::OP_ENQUEUE) begin
         rsp_in.status = (sock_bad || !found_ff) ? psdq_pkg::ST_DROPPED
                                                 : psdq_pkg::ST_ENQUEUED;
      end else if (sock_bad || head_cur[AW]) begin
         rsp_in.status = psdq_pkg::ST_EMPTY;
      end else if (time_q > now_ff) begin
         rsp_in.status = psdq_pkg::ST_NOT_DUE;
      end else begin
         rsp_in.status = psdq_pkg::ST_DELIVERED;
         rsp_in.out_handle = desc_q.packet_handle;
         rsp_in.out_source = desc_q.source_address;
         rsp_in.release_time = time_q;
         rsp_in.out_payload_size = desc_q.payload_size;
         rsp_in.out_wire_size = desc_q.wire_size;
         rsp_in.out_stream_flag = desc_q.stream_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_in;
         sock_ff <= sock_in;
         arr_ff <= arrival_in;
         dly_ff <= delay_in;
         now_ff <= now_in;
         desc_ff <= desc_in;
      end
      if (cmd.mul) begin
         prod_ff <= dly_ff * 26'(psdq_pkg::US_PER_MS);
         rel_ff <= (rel_full > 42'(psdq_pkg::TIME_MAX)) ? psdq_pkg::TIME_MAX
                                                         : rel_full[39:0];
      end
      if (cmd.rd_next) begin
         prev_ff <= head_cur[AW-1:0];
         nxt_ff <= link_q;
      end else if (cmd.advance) begin
         prev_ff <= nxt_ff[AW-1:0];
         nxt_ff <= link_q;
      end
      if (cmd.set_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.is_enq = (op_ff == psdq_pkg::OP_ENQUEUE);
   assign stat.sock_bad = sock_bad;
   assign stat.scan_done = found_ff || scan_ff[AW];
   assign stat.pool_full = !found_ff;
   assign stat.head_nil = head_cur[AW];
   assign stat.head_later = time_q > rel_ff;
   assign stat.head_not_due = time_q > now_ff;
   assign stat.next_nil = nxt_ff[AW];
   assign stat.next_earlier = time_q < rel_ff;

   // free search, heads, response flag
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
         scan_ff <= '0;
         found_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
         for (int s = 0; s < SOCKET_COUNT; s++) begin
            head_ff[s] <= NIL;
         end
      end else begin
         if (cmd.capture) begin
            scan_ff <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan && !found_ff && !scan_ff[AW]) begin
            if (free_ff[scan_ff[AW-1:0]]) begin
               found_ff <= 1'b1;
               new_ff <= scan_ff[AW-1:0];
            end
            scan_ff <= (scan_ff[AW-1:0] == AW'(POOL_ENTRIES - 1))
                       ? NIL : scan_ff + 1'b1;
         end
         if (cmd.wr_new) begin
            free_ff[new_ff] <= 1'b0;
         end
         if (cmd.link_head) begin
            head_ff[sidx] <= {1'b0, new_ff};
         end
         if (cmd.pop) begin
            head_ff[sidx] <= link_q;
            free_ff[head_cur[AW-1:0]] <= 1'b1;
         end
         if (cmd.set_rsp) begin
            rsp_full_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_full_ff <= 1'b0;
         end
      end
   end

   assign rsp_full = rsp_full_ff;
   assign rsp = rsp_ff;
endmodule

### rtl/core/per_socket_packet_delay_queue_unit.sv
// per_socket_packet_delay_queue_unit: top level of the per-socket delay queue
// depends on psdq_pkg, psdq_if, psdq_ctrl, psdq_dp
//
// usage
// req channel: one request, enqueue (operation 0) or dequeue (operation 1)
// rsp channel: exactly one response per request, status plus packet fields
// enqueue: the response is set by the free search, the head read and compare,
//    and the sorted list walk over the entries after the head; a dropped
//    request answers after the free search
// dequeue: the response is set by the registered pool RAM read of the head entry
// one request is worked at a time; the next is taken after the response is
// issued, once the controller is idle and the response register is empty
// reset: all socket lists empty and all pool entries free, no clearing pass
// a stalled rsp holds its response and req_ready stays low until taken

module per_socket_packet_delay_queue_unit #(
   parameter int SOCKET_COUNT = 6,
   parameter int POOL_ENTRIES = 64
) (
   input  logic clock,
   input  logic reset,
   psdq_if.sink   req_channel,
   psdq_if.source rsp_channel
);
   psdq_pkg::cmd_type  cmd;
   psdq_pkg::stat_type stat;
   logic req_fire, rsp_full;

   assign req_fire = req_channel.valid && req_channel.ready;

   psdq_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_ready(req_channel.ready),
      .rsp_full, .stat, .cmd);

   psdq_dp #(.SOCKET_COUNT(SOCKET_COUNT), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
      .clock, .reset,
      .op_in(req_channel.payload.operation),
      .sock_in(req_channel.payload.socket),
      .arrival_in(req_channel.payload.arrival_time),
      .delay_in(req_channel.payload.delay_ms),
      .now_in(req_channel.payload.now_time),
      .desc_in({req_channel.payload.packet_handle,
                req_channel.payload.source_address,
                req_channel.payload.payload_size,
                req_channel.payload.wire_size,
                req_channel.payload.stream_flag}),
      .cmd, .stat,
      .rsp_take(rsp_channel.valid && rsp_channel.ready),
      .rsp_full, .rsp(rsp_channel.payload));

   assign rsp_channel.valid = rsp_full;
endmodule

### rtl/core/psdq_checker.sv
// psdq_checker: port-level assertions for the delay queue top level
// depends on per_socket_packet_delay_queue_unit

module psdq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status
);
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response held");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd4) else $error("bad status");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response lost");
endmodule

bind per_socket_packet_delay_queue_unit psdq_checker u_checker (
   .clock, .reset,
   .req_valid(req_channel.valid), .req_ready(req_channel.ready),
   .rsp_valid(rsp_channel.valid), .rsp_ready(rsp_channel.ready),
   .rsp_status(rsp_channel.payload.status));
